### sv/fastkdf_blake2s_engine_top_defines.svh
// Assertion macros shared by the FastKDF engine RTL.
`ifndef FASTKDF_BLAKE2S_ENGINE_TOP_DEFINES_SVH
`define FASTKDF_BLAKE2S_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FKB_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fkb check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define FKB_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fkb check failed");

`endif

### sv/fkb_pkg.sv
// Types, constants and helper functions of the FastKDF Blake2s engine.
package fkb_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int BANK_ROWS    = BUFFER_BYTES / 4;
    localparam int ROW_W        = $clog2(BANK_ROWS);
    localparam int KDF_ITER     = 32;
    localparam int HASH_ROUNDS  = 10;
    localparam int COMP_STEPS   = HASH_ROUNDS * 4;
    localparam int HDR_WORDS    = 20;
    localparam int STATE_WORDS  = 64;
    localparam int RES_FIRST    = 64;
    localparam int RES_LAST     = 8;
    localparam int MSG_WORDS    = 16;
    localparam int KEY_WORDS    = 8;

    localparam logic [31:0] PARAM_WORD = 32'h0101_2020;
    localparam logic [31:0] T0_KEY     = 32'd64;
    localparam logic [31:0] T0_MSG     = 32'd128;
    localparam logic [31:0] F0_LAST    = 32'hFFFF_FFFF;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ROW_W-1:0]  row_t;

    localparam logic [31:0] BLK_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_LOAD,
        S_PRIME,
        S_COMP,
        S_FIN,
        S_SUM,
        S_XOR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quad_t;

    function automatic logic [3:0] sigma_idx(logic [3:0] rnd, logic [3:0] pos);
        logic [3:0] r;
        r = '0;
        if (rnd < 4'(HASH_ROUNDS))
            r = SIGMA[rnd][pos];
        return r;
    endfunction

    // one half of G: first half rotates 16/12, second half 8/7
    function automatic quad_t half_g(quad_t q, logic [31:0] x, logic hi);
        quad_t       r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] t;
        a = q.a + q.b + x;
        t = q.d ^ a;
        d = hi ? {t[7:0], t[31:8]} : {t[15:0], t[31:16]};
        c = q.c + d;
        t = q.b ^ c;
        b = hi ? {t[6:0], t[31:7]} : {t[11:0], t[31:12]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

    // byte lane of a word that lands in bank j for byte address p
    function automatic logic [1:0] bank_sel(addr_t p, logic [1:0] j);
        return j - p[1:0];
    endfunction

    function automatic row_t bank_row(addr_t p, logic [1:0] j);
        addr_t s;
        s = p + ADDR_W'(bank_sel(p, j));
        return s[ADDR_W-1:2];
    endfunction

    function automatic logic [31:0] gather(logic [3:0][7:0] q, logic [1:0] sh);
        logic [31:0] w;
        logic [1:0]  k;
        w = '0;
        for (int n = 0; n < 4; n++) begin
            k = sh + 2'(n);
            w[8*n +: 8] = q[k];
        end
        return w;
    endfunction

endpackage

### sv/fastkdf_blake2s_engine_top.sv
// FastKDF engine (NeoScrypt style) around one iterated Blake2s core.
//
// Words are taken one per cycle while loading; in_stall is high whenever a
// derivation runs. After the last of 20 header words (func 0) the header is
// first replicated over buffers A and B. Each of the 32 KDF iterations then
// runs two Blake2s compressions (16-word message fetch from the banked byte
// buffers plus 40 steps of four parallel half-G lanes), the offset byte sum
// and the read-modify-write of the digest into B. A derivation is followed
// by 64 (func 0) or 8 (func 1) result beats; each beat is read from the
// buffers only after the previous one is taken. Buffers A and B are four
// byte banks each, so an unaligned word is one access per bank.
`include "fastkdf_blake2s_engine_top_defines.svh"

module fastkdf_blake2s_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_word,
    output logic        last_word
);
    import fkb_pkg::*;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [4:0]  iter_reg, iter_next;
    logic        second_reg, second_next;
    addr_t       offset_reg, offset_next;
    logic [7:0]  sum_reg, sum_next;
    logic [6:0]  load_count_reg, load_count_next;
    logic        load_mode_reg, load_mode_next;
    logic        kdf_mode_reg, kdf_mode_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        last_word_reg, last_word_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [5:0]  pidx_reg, pidx_next;
    logic [1:0]  a_sh_reg, b_sh_reg;
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [16];
    logic [31:0] v_next [16];

    // buffer ports
    logic        a_we, b_we;
    addr_t       a_waddr, b_waddr, a_raddr, b_raddr;
    logic [31:0] a_wdata, b_wdata;
    logic [3:0][7:0] a_q, b_q;
    logic [31:0] a_word, b_word;
    logic [7:0]  mem_a [4][BANK_ROWS];
    logic [7:0]  mem_b [4][BANK_ROWS];

    // message word copies, one per G lane
    logic        m_we;
    logic [3:0]  m_widx;
    logic [31:0] m_wdata;
    logic [3:0]  m_ridx [4];
    logic [31:0] m_q [4];
    logic [31:0] mem_m [4][MSG_WORDS];
    logic [5:0]  m_step;

    logic        in_acc, out_acc;
    logic [6:0]  ld_k;
    logic        ld_done;
    logic [6:0]  cm1;
    logic [6:0]  nres;
    logic [2:0]  hsel;
    logic [31:0] h_word;
    logic [7:0]  sum_add;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign last_word = last_word_reg;
    assign out_acc   = out_valid_reg && !out_stall;

    assign ld_k    = (func != load_mode_reg) ? 7'd0 : load_count_reg;
    assign ld_done = (ld_k + 7'd1) == (func ? 7'(STATE_WORDS) : 7'(HDR_WORDS));
    assign cm1     = cnt_reg - 7'd1;
    assign nres    = kdf_mode_reg ? 7'(RES_LAST) : 7'(RES_FIRST);
    assign hsel    = (state_reg == S_XOR) ? cm1[2:0] : cnt_reg[2:0];
    assign h_word  = h_reg[hsel];
    assign sum_add = sum_reg + h_word[7:0] + h_word[15:8] + h_word[23:16] + h_word[31:24];
    assign m_step  = (state_reg == S_PRIME) ? 6'd0 : (cnt_reg[5:0] + 6'd1);
    assign a_word  = gather(a_q, a_sh_reg);
    assign b_word  = gather(b_q, b_sh_reg);

    for (genvar j = 0; j < 4; j++) begin : g_bank
        row_t       a_wrow, a_rrow, b_wrow, b_rrow;
        logic [7:0] a_wbyte, b_wbyte;
        assign a_wrow  = bank_row(a_waddr, 2'(j));
        assign a_rrow  = bank_row(a_raddr, 2'(j));
        assign b_wrow  = bank_row(b_waddr, 2'(j));
        assign b_rrow  = bank_row(b_raddr, 2'(j));
        assign a_wbyte = a_wdata[8*bank_sel(a_waddr, 2'(j)) +: 8];
        assign b_wbyte = b_wdata[8*bank_sel(b_waddr, 2'(j)) +: 8];

        always_ff @(posedge clk)
        begin
            if (a_we)
                mem_a[j][a_wrow] <= a_wbyte;
            a_q[j] <= mem_a[j][a_rrow];
        end

        always_ff @(posedge clk)
        begin
            if (b_we)
                mem_b[j][b_wrow] <= b_wbyte;
            b_q[j] <= mem_b[j][b_rrow];
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign m_ridx[l] = sigma_idx({1'b0, m_step[5:3]} << 1 | {3'b0, m_step[2]},
                                     {m_step[1], 2'(l), m_step[0]});

        always_ff @(posedge clk)
        begin
            if (m_we)
                mem_m[l][m_widx] <= m_wdata;
            m_q[l] <= mem_m[l][m_ridx[l]];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc && ld_done) state_next = func ? S_LOAD : S_FILL;
            S_FILL:  if (cnt_reg == 7'(STATE_WORDS)) state_next = S_LOAD;
            S_LOAD:  if (cnt_reg == 7'(MSG_WORDS)) state_next = S_PRIME;
            S_PRIME: state_next = S_COMP;
            S_COMP:  if (cnt_reg == 7'(COMP_STEPS - 1)) state_next = S_FIN;
            S_FIN:   state_next = second_reg ? S_SUM : S_LOAD;
            S_SUM:   if (cnt_reg == 7'd7) state_next = S_XOR;
            S_XOR:
            begin
                if (cnt_reg == 7'(KEY_WORDS))
                    state_next = (iter_reg == 5'(KDF_ITER - 1)) ? S_OUT : S_LOAD;
            end
            S_OUT:   if (out_acc && last_word_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        quad_t qin;
        quad_t qo;
        logic  diag;
        logic  half;

        cnt_next        = cnt_reg;
        iter_next       = iter_reg;
        second_next     = second_reg;
        offset_next     = offset_reg;
        sum_next        = sum_reg;
        load_count_next = load_count_reg;
        load_mode_next  = load_mode_reg;
        kdf_mode_next   = kdf_mode_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        last_word_next  = last_word_reg;
        rd_pend_next    = 1'b0;
        pidx_next       = pidx_reg;
        h_next          = h_reg;
        v_next          = v_reg;
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = '0;
        b_waddr = '0;
        a_wdata = '0;
        b_wdata = '0;
        a_raddr = '0;
        b_raddr = '0;
        m_we    = 1'b0;
        m_widx  = '0;
        m_wdata = '0;
        diag    = cnt_reg[1];
        half    = cnt_reg[0];
        qin     = '0;
        qo      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    load_mode_next = func;
                    b_we    = 1'b1;
                    b_waddr = {ld_k[5:0], 2'b00};
                    b_wdata = data_word;
                    a_we    = !func;
                    a_waddr = {ld_k[5:0], 2'b00};
                    a_wdata = data_word;
                    if (ld_done)
                    begin
                        load_count_next = '0;
                        kdf_mode_next   = func;
                        cnt_next        = func ? 7'd0 : 7'(HDR_WORDS);
                        offset_next     = '0;
                        iter_next       = '0;
                        second_next     = 1'b0;
                    end
                    else
                    begin
                        load_count_next = ld_k + 7'd1;
                    end
                end
            end
            S_FILL:
            begin
                // row j copies row j-20; each row is read in the cycle before it is written
                if (cnt_reg < 7'(STATE_WORDS))
                    a_raddr = {6'(cnt_reg - 7'(HDR_WORDS)), 2'b00};
                if (cnt_reg > 7'(HDR_WORDS))
                begin
                    a_we    = 1'b1;
                    a_waddr = {cm1[5:0], 2'b00};
                    a_wdata = a_word;
                    b_we    = 1'b1;
                    b_waddr = {cm1[5:0], 2'b00};
                    b_wdata = a_word;
                end
                cnt_next = (cnt_reg == 7'(STATE_WORDS)) ? 7'd0 : cnt_reg + 7'd1;
            end
            S_LOAD:
            begin
                if (cnt_reg < 7'(MSG_WORDS))
                begin
                    a_raddr = offset_reg + {cnt_reg[5:0], 2'b00};
                    b_raddr = offset_reg + {cnt_reg[5:0], 2'b00};
                end
                if (cnt_reg != 7'd0)
                begin
                    m_we   = 1'b1;
                    m_widx = cm1[3:0];
                    if (second_reg)
                        m_wdata = a_word;
                    else if (cm1 < 7'(KEY_WORDS))
                        m_wdata = b_word;
                    else
                        m_wdata = '0;
                end
                cnt_next = (cnt_reg == 7'(MSG_WORDS)) ? 7'd0 : cnt_reg + 7'd1;
            end
            S_PRIME:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (!second_reg)
                        h_next[i] = (i == 0) ? (BLK_IV[i] ^ PARAM_WORD) : BLK_IV[i];
                    v_next[i]     = h_next[i];
                    v_next[i + 8] = BLK_IV[i];
                end
                v_next[12] = BLK_IV[4] ^ (second_reg ? T0_MSG : T0_KEY);
                v_next[14] = BLK_IV[6] ^ (second_reg ? F0_LAST : 32'd0);
                cnt_next   = '0;
            end
            S_COMP:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    qin.a = v_reg[l];
                    qin.b = diag ? v_reg[4 + ((l + 1) % 4)]  : v_reg[4 + l];
                    qin.c = diag ? v_reg[8 + ((l + 2) % 4)]  : v_reg[8 + l];
                    qin.d = diag ? v_reg[12 + ((l + 3) % 4)] : v_reg[12 + l];
                    qo = half_g(qin, m_q[l], half);
                    v_next[l] = qo.a;
                    if (diag)
                    begin
                        v_next[4 + ((l + 1) % 4)]  = qo.b;
                        v_next[8 + ((l + 2) % 4)]  = qo.c;
                        v_next[12 + ((l + 3) % 4)] = qo.d;
                    end
                    else
                    begin
                        v_next[4 + l]  = qo.b;
                        v_next[8 + l]  = qo.c;
                        v_next[12 + l] = qo.d;
                    end
                end
                cnt_next = (cnt_reg == 7'(COMP_STEPS - 1)) ? 7'd0 : cnt_reg + 7'd1;
            end
            S_FIN:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                cnt_next = '0;
                sum_next = '0;
                if (!second_reg)
                    second_next = 1'b1;
            end
            S_SUM:
            begin
                sum_next = sum_add;
                if (cnt_reg == 7'd7)
                begin
                    offset_next = sum_add;
                    cnt_next    = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_XOR:
            begin
                // read word i while writing word i-1 back
                if (cnt_reg < 7'(KEY_WORDS))
                    b_raddr = offset_reg + {cnt_reg[5:0], 2'b00};
                if (cnt_reg != 7'd0)
                begin
                    b_we    = 1'b1;
                    b_waddr = offset_reg + {cm1[5:0], 2'b00};
                    b_wdata = b_word ^ h_word;
                end
                if (cnt_reg == 7'(KEY_WORDS))
                begin
                    cnt_next    = '0;
                    second_next = 1'b0;
                    if (iter_reg != 5'(KDF_ITER - 1))
                        iter_next = iter_reg + 5'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg && !rd_pend_reg && cnt_reg < nres)
                begin
                    a_raddr      = {cnt_reg[5:0], 2'b00};
                    b_raddr      = offset_reg + {cnt_reg[5:0], 2'b00};
                    rd_pend_next = 1'b1;
                    pidx_next    = cnt_reg[5:0];
                    cnt_next     = cnt_reg + 7'd1;
                end
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = a_word ^ b_word;
                    last_word_next = ({1'b0, pidx_reg} == (nres - 7'd1));
                end
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (last_word_reg)
                        cnt_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            iter_reg       <= '0;
            second_reg     <= 1'b0;
            offset_reg     <= '0;
            load_count_reg <= '0;
            load_mode_reg  <= 1'b0;
            kdf_mode_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            iter_reg       <= iter_next;
            second_reg     <= second_next;
            offset_reg     <= offset_next;
            load_count_reg <= load_count_next;
            load_mode_reg  <= load_mode_next;
            kdf_mode_reg   <= kdf_mode_next;
            out_valid_reg  <= out_valid_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        out_word_reg  <= out_word_next;
        last_word_reg <= last_word_next;
        pidx_reg      <= pidx_next;
        a_sh_reg      <= a_raddr[1:0];
        b_sh_reg      <= b_raddr[1:0];
        h_reg         <= h_next;
        v_reg         <= v_next;
    end

    `FKB_ASSERT_IMP(a_out_only_in_out, out_valid_reg, state_reg == S_OUT)
    `FKB_ASSERT_IMP(a_pend_excl, rd_pend_reg, !out_valid_reg)
    `FKB_ASSERT_IMP(a_comp_range, state_reg == S_COMP, cnt_reg < 7'(COMP_STEPS))
    `FKB_ASSERT_NXT(a_last_to_idle, out_valid && !out_stall && last_word, state_reg == S_IDLE)
    `FKB_ASSERT_NXT(a_iter_to_out, state_reg == S_XOR && cnt_reg == 7'd8 && iter_reg == 5'd31, state_reg == S_OUT)

endmodule
